// ===== src/sfcd_pkg.sv =====
// Shared types, constants and the CRC-8 byte step of the sensor frame decoder.
// No dependencies; every other file but sfcd_if refers to it by scoped names.
package sfcd_pkg;

    // CRC-8, polynomial 0x31, seed 0xFF, MSB first, no reflection, no final xor
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam int          BUSY_BIT    = 7;

    // Byte positions within the seven-byte frame
    localparam logic [2:0]  POS_STATUS  = 3'd0;
    localparam logic [2:0]  POS_HUM_HI  = 3'd1;
    localparam logic [2:0]  POS_HUM_MID = 3'd2;
    localparam logic [2:0]  POS_SPLIT   = 3'd3;
    localparam logic [2:0]  POS_TMP_MID = 3'd4;
    localparam logic [2:0]  POS_TMP_LO  = 3'd5;
    localparam logic [2:0]  POS_CRC     = 3'd6;

    // Fixed-point scaling: value = floor(code * scale / 2^20), less TMP_OFFSET for temperature
    localparam int          CODE_W      = 20;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TMP_SCALE   = 15'd20000;
    localparam logic [15:0] TMP_OFFSET  = 16'd5000;

    localparam int          QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_CRC  = 2'd2
    } t_frame_status;

    // One finished frame as handed from the front to the back
    typedef struct packed {
        t_frame_status       status;
        logic [CODE_W-1:0]   hum;
        logic [CODE_W-1:0]   tmp;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Advance the CRC by one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== src/sfcd_if.sv =====
// Handshake channels of the sensor frame decoder: byte input and result output.
// Depends on nothing; widths follow the frame field definitions.
interface sfcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [19:0]        humidity_code;
    logic [19:0]        temperature_code;
    logic [13:0]        humidity_centi;
    logic signed [14:0] temperature_centi;

    modport source (output valid, output frame_status, output humidity_code,
                    output temperature_code, output humidity_centi,
                    output temperature_centi, input ready);
    modport sink   (input valid, input frame_status, input humidity_code,
                    input temperature_code, input humidity_centi,
                    input temperature_centi, output ready);
endinterface

// ===== src/sensor_frame_crc_decode.sv =====
// Top level of the sensor frame decoder: front end, record queue, back end.
// Depends on sfcd_pkg, sfcd_if, sfcd_front, sfcd_queue and sfcd_back.
//
// Takes one frame byte per cycle (status byte, five data bytes, CRC byte) and
// gives one result per seven-byte frame: status (ok, busy, CRC mismatch), the
// two 20-bit raw codes and humidity and temperature in hundredths. A start
// flag forces the byte to be the status byte and drops any partial frame. The
// front end runs the CRC-8 and code assembly at one byte per cycle; the input
// stalls only while the two-entry record queue is full. The back end is a
// multiply stage followed by the output register, pipelined so a new result
// can enter each cycle while the output is not stalled; once the CRC byte
// is transferred, the record passes through the queue, the multiply stage
// and the output register. Failed frames carry zeros in all value fields.
module sensor_frame_crc_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfcd_byte_if.sink     i_in,
    sfcd_result_if.source o_out
);

    logic                 w_push, w_pop;
    sfcd_pkg::t_frame_rec w_push_rec, w_head_rec;
    sfcd_pkg::t_q_status  w_q_stat;

    sfcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_rec    (w_push_rec)
    );

    sfcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_head_rec),
        .o_stat  (w_q_stat)
    );

    sfcd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (w_head_rec),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("record pushed into full queue");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("record popped from empty queue");

    // A failed frame carries zero values
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.frame_status != sfcd_pkg::ST_OK)) |->
        (o_out.humidity_code == '0 && o_out.temperature_code == '0 &&
         o_out.humidity_centi == '0 && o_out.temperature_centi == '0))
        else $error("failed frame with non-zero fields");

    // A pushed record reaches the queue
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> !w_q_stat.empty)
        else $error("pushed record lost");

endmodule

// ===== src/sfcd_front.sv =====
// Front end: takes frame bytes, tracks position, runs the CRC, builds raw codes.
// Depends on sfcd_pkg and sfcd_byte_if; pushes one record per frame.
module sfcd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sfcd_byte_if.sink            i_in,
    input  sfcd_pkg::t_q_status  i_q_stat,
    output logic                 o_push,
    output sfcd_pkg::t_frame_rec o_rec
);

    logic [7:0]  r_crc, n_crc;
    logic [2:0]  r_pos, n_pos;
    logic        r_busy, n_busy;
    logic [19:0] r_hum, n_hum;
    logic [19:0] r_tmp, n_tmp;
    logic [2:0]  w_pos;
    logic        w_accept;
    logic [7:0]  w_b;

    // Stall only while the queue has no room
    assign i_in.ready = !i_q_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.data_byte;

    // Start flag realigns; an out-of-range position counts as the status byte
    always_comb begin
        w_pos = i_in.frame_start ? sfcd_pkg::POS_STATUS : r_pos;
        if (w_pos > sfcd_pkg::POS_CRC) begin
            w_pos = sfcd_pkg::POS_STATUS;
        end
    end

    // Advance the frame state on each transfer
    always_comb begin
        n_crc  = r_crc;
        n_pos  = r_pos;
        n_busy = r_busy;
        n_hum  = r_hum;
        n_tmp  = r_tmp;
        o_push = 1'b0;
        if (r_busy) begin
            o_rec.status = sfcd_pkg::ST_BUSY;
        end else if (r_crc != w_b) begin
            o_rec.status = sfcd_pkg::ST_CRC;
        end else begin
            o_rec.status = sfcd_pkg::ST_OK;
        end
        o_rec.hum = (o_rec.status == sfcd_pkg::ST_OK) ? r_hum : '0;
        o_rec.tmp = (o_rec.status == sfcd_pkg::ST_OK) ? r_tmp : '0;
        if (w_accept) begin
            case (w_pos)
                sfcd_pkg::POS_STATUS: begin
                    n_busy = w_b[sfcd_pkg::BUSY_BIT];
                    n_hum  = '0;
                    n_tmp  = '0;
                    n_crc  = sfcd_pkg::crc8_step(sfcd_pkg::CRC_INIT, w_b);
                end
                sfcd_pkg::POS_HUM_HI:  n_hum[19:12] = w_b;
                sfcd_pkg::POS_HUM_MID: n_hum[11:4]  = w_b;
                sfcd_pkg::POS_SPLIT: begin
                    n_hum[3:0]   = w_b[7:4];
                    n_tmp[19:16] = w_b[3:0];
                end
                sfcd_pkg::POS_TMP_MID: n_tmp[15:8] = w_b;
                sfcd_pkg::POS_TMP_LO:  n_tmp[7:0]  = w_b;
                default: begin
                    o_push = 1'b1;
                end
            endcase
            if (w_pos == sfcd_pkg::POS_CRC) begin
                // Frame complete: return to the initial state
                n_crc  = sfcd_pkg::CRC_INIT;
                n_pos  = sfcd_pkg::POS_STATUS;
                n_busy = 1'b0;
                n_hum  = '0;
                n_tmp  = '0;
            end else begin
                n_pos = w_pos + 3'd1;
                if (w_pos != sfcd_pkg::POS_STATUS) begin
                    n_crc = sfcd_pkg::crc8_step(r_crc, w_b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= sfcd_pkg::CRC_INIT;
            r_pos  <= sfcd_pkg::POS_STATUS;
            r_busy <= 1'b0;
            r_hum  <= '0;
            r_tmp  <= '0;
        end else begin
            r_crc  <= n_crc;
            r_pos  <= n_pos;
            r_busy <= n_busy;
            r_hum  <= n_hum;
            r_tmp  <= n_tmp;
        end
    end

endmodule

// ===== src/sfcd_queue.sv =====
// Short frame record queue between the front end and the conversion back end.
// Depends on sfcd_pkg for the record and status types.
module sfcd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfcd_pkg::t_frame_rec i_rec,
    input  logic                 i_pop,
    output sfcd_pkg::t_frame_rec o_rec,
    output sfcd_pkg::t_q_status  o_stat
);

    localparam int PTR_W = (sfcd_pkg::QUEUE_DEPTH > 1) ? $clog2(sfcd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sfcd_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sfcd_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(sfcd_pkg::QUEUE_DEPTH);

    sfcd_pkg::t_frame_rec r_mem [sfcd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    assign o_stat.full  = (r_count == DEPTH_C);
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_mem[r_rd_ptr];

    // Store a record at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/sfcd_back.sv =====
// Back end: scales raw codes to hundredths in two stages and holds the result.
// Depends on sfcd_pkg and sfcd_result_if; pops records from the queue.
module sfcd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfcd_pkg::t_frame_rec i_rec,
    input  sfcd_pkg::t_q_status  i_q_stat,
    output logic                 o_pop,
    sfcd_result_if.source        o_out
);

    logic                    r_a_valid;
    sfcd_pkg::t_frame_status r_a_status;
    logic [19:0]             r_a_hum, r_a_tmp;
    logic [33:0]             r_a_hprod;
    logic [34:0]             r_a_tprod;

    logic                    r_b_valid;
    logic [1:0]              r_b_status;
    logic [19:0]             r_b_hum, r_b_tmp;
    logic [13:0]             r_b_hc;
    logic [14:0]             r_b_tc;

    logic        w_en_a, w_en_b;
    logic [33:0] w_hprod;
    logic [34:0] w_tprod;
    logic [15:0] w_tc;

    // Each stage moves when the one after it has room
    assign w_en_b = !r_b_valid || o_out.ready;
    assign w_en_a = !r_a_valid || w_en_b;
    assign o_pop  = w_en_a && !i_q_stat.empty;

    assign w_hprod = 34'(i_rec.hum) * 34'(sfcd_pkg::HUM_SCALE);
    assign w_tprod = 35'(i_rec.tmp) * 35'(sfcd_pkg::TMP_SCALE);
    assign w_tc    = {1'b0, r_a_tprod[34:20]} - sfcd_pkg::TMP_OFFSET;

    // Stage A: multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en_a) begin
            r_a_valid <= !i_q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_status <= i_rec.status;
            r_a_hum    <= i_rec.hum;
            r_a_tmp    <= i_rec.tmp;
            r_a_hprod  <= w_hprod;
            r_a_tprod  <= w_tprod;
        end
    end

    // Stage B: take the floor, apply the offset, zero failed frames
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_status <= r_a_status;
            if (r_a_status == sfcd_pkg::ST_OK) begin
                r_b_hum <= r_a_hum;
                r_b_tmp <= r_a_tmp;
                r_b_hc  <= r_a_hprod[33:20];
                r_b_tc  <= w_tc[14:0];
            end else begin
                r_b_hum <= '0;
                r_b_tmp <= '0;
                r_b_hc  <= '0;
                r_b_tc  <= '0;
            end
        end
    end

    assign o_out.valid             = r_b_valid;
    assign o_out.frame_status      = r_b_status;
    assign o_out.humidity_code     = r_b_hum;
    assign o_out.temperature_code  = r_b_tmp;
    assign o_out.humidity_centi    = r_b_hc;
    assign o_out.temperature_centi = $signed(r_b_tc);

endmodule
